// ===== hdl/hpm_pkg.sv =====
package hpm_pkg;

   localparam int MAX_ARITY     = 8;
   localparam int NODE_ID_WIDTH = 32;
   localparam int INDEX_WIDTH   = 16;

   localparam int NODE_FIELD_W = 32;
   localparam int LEN_W        = 4;
   localparam int PAT_W        = 8;
   localparam int PAT_FIELD_W  = 64;
   localparam int OUT_INDEX_W  = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_W    = 1;

   localparam int LANE_W     = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;
   localparam int CNT_W      = $clog2(MAX_ARITY + 1);
   localparam int NODE_CMP_W = (NODE_ID_WIDTH < NODE_FIELD_W) ? NODE_ID_WIDTH : NODE_FIELD_W;
   localparam int IDX_EXT_W  = (INDEX_WIDTH > OUT_INDEX_W) ? INDEX_WIDTH : OUT_INDEX_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH   = 1'b0,
      CSR_PATTERN_ELEMENTS = 1'b1
   } csr_index_type;

   typedef logic [NODE_CMP_W-1:0] node_id_type;
   typedef logic [PAT_W-1:0]      pat_value_type;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] node_0;
      logic [NODE_FIELD_W-1:0] node_1;
      logic [NODE_FIELD_W-1:0] node_2;
      logic [NODE_FIELD_W-1:0] node_3;
      logic [NODE_FIELD_W-1:0] node_4;
      logic [NODE_FIELD_W-1:0] node_5;
      logic [NODE_FIELD_W-1:0] node_6;
      logic [NODE_FIELD_W-1:0] node_7;
      logic [LEN_W-1:0]        edge_length;
      logic                    edge_alive;
      logic                    last_edge;
   } req_type;

   typedef struct packed {
      logic                   edge_matches;
      logic                   any_match;
      logic [OUT_INDEX_W-1:0] first_match_index;
      logic                   list_done;
   } rsp_type;

   typedef struct packed {
      logic                 node_first;
      logic [LANE_W-1:0]    first_pos;
      logic                 pat_first;
      logic [MAX_ARITY-1:0] pat_lt;
   } lane_info_type;

   function automatic logic [CNT_W-1:0] popcount(input logic [MAX_ARITY-1:0] v);
      logic [CNT_W-1:0] r;
      r = '0;
      for (int k = 0; k < MAX_ARITY; k++) begin
         r = r + CNT_W'(v[k]);
      end
      return r;
   endfunction

   function automatic logic [OUT_INDEX_W-1:0] to_out_index(input logic [INDEX_WIDTH-1:0] v);
      logic [IDX_EXT_W-1:0] ext;
      ext = IDX_EXT_W'(v);
      return ext[OUT_INDEX_W-1:0];
   endfunction

endpackage

// ===== hdl/hyperedge_pattern_match.sv =====
// Hyperedge pattern matcher.
// Input channel req_*: one hyperedge per transfer (eight node IDs, length,
// alive flag, last-of-list flag). Result channel rsp_*: exactly one result
// per input transfer, in order: the edge's match flag, the running found flag
// of the list, the index of the first matching edge and the list end flag.
// csr_*: write pattern_length (index 0) and pattern_elements (index 1) while
// no edge is in flight; writes take effect at the next clock edge.
// An input transfer is registered in the first stage and its result in the
// result register driving rsp_valid. Throughput: one edge per cycle while
// rsp_ready is high. Eight lanes compare their node and pattern value against
// all earlier positions in the first stage; the merge stage counts ranks and
// distinct values and updates the list state as the result is registered.
// Reset clears the pattern registers, the edge index, the found flag and the
// pipeline valids. When rsp_ready is low the result holds and one further
// edge is parked in the first stage; req_ready drops only when both are full.
// The edge index saturates at its maximum and returns to zero after the last
// edge of a list.
module hyperedge_pattern_match
   import hpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]       pattern_length_ff;
   logic [PAT_FIELD_W-1:0] pattern_elements_ff;

   node_id_type   [7:0]           node_all;
   node_id_type   [MAX_ARITY-1:0] node_id;
   pat_value_type [MAX_ARITY-1:0] pat_value;
   lane_info_type [MAX_ARITY-1:0] lane_in;

   logic                          s1_valid_ff, s1_valid_in;
   lane_info_type [MAX_ARITY-1:0] s1_lane_ff;
   logic [LEN_W-1:0]              s1_len_ff;
   logic                          s1_alive_ff;
   logic                          s1_last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [INDEX_WIDTH-1:0] edge_position_ff, edge_position_in;
   logic                   found_ff, found_in;
   logic [INDEX_WIDTH-1:0] first_index_ff, first_index_in;

   logic out_free;
   logic take;
   logic advance;
   logic match;

   assign node_all[0] = req_data.node_0[NODE_CMP_W-1:0];
   assign node_all[1] = req_data.node_1[NODE_CMP_W-1:0];
   assign node_all[2] = req_data.node_2[NODE_CMP_W-1:0];
   assign node_all[3] = req_data.node_3[NODE_CMP_W-1:0];
   assign node_all[4] = req_data.node_4[NODE_CMP_W-1:0];
   assign node_all[5] = req_data.node_5[NODE_CMP_W-1:0];
   assign node_all[6] = req_data.node_6[NODE_CMP_W-1:0];
   assign node_all[7] = req_data.node_7[NODE_CMP_W-1:0];

   for (genvar i = 0; i < MAX_ARITY; i++) begin : g_lane
      assign node_id[i]   = node_all[i];
      assign pat_value[i] = pattern_elements_ff[PAT_W*i +: PAT_W];
      hpm_lane u_lane (
         .lane_id   (LANE_W'(i)),
         .node_id   (node_id),
         .pat_value (pat_value),
         .info      (lane_in[i])
      );
   end

   hpm_merge u_merge (
      .lane           (s1_lane_ff),
      .edge_length    (s1_len_ff),
      .edge_alive     (s1_alive_ff),
      .pattern_length (pattern_length_ff),
      .edge_matches   (match)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign take      = req_valid && req_ready;
   assign advance   = s1_valid_ff && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      found_in       = found_ff || match;
      first_index_in = (match && !found_ff) ? edge_position_ff : first_index_ff;

      rsp_data_in.edge_matches      = match;
      rsp_data_in.any_match         = found_in;
      rsp_data_in.first_match_index = found_in ? to_out_index(first_index_in) : '0;
      rsp_data_in.list_done         = s1_last_ff;

      edge_position_in = edge_position_ff;
      if (s1_last_ff) begin
         edge_position_in = '0;
         found_in         = 1'b0;
         first_index_in   = '0;
      end else if (edge_position_ff != '1) begin
         edge_position_in = edge_position_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff   <= '0;
         pattern_elements_ff <= '0;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         edge_position_ff    <= '0;
         found_ff            <= 1'b0;
         first_index_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_PATTERN_LENGTH:   pattern_length_ff   <= csr_wdata[LEN_W-1:0];
               CSR_PATTERN_ELEMENTS: pattern_elements_ff <= csr_wdata[PAT_FIELD_W-1:0];
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            edge_position_ff <= edge_position_in;
            found_ff         <= found_in;
            first_index_ff   <= first_index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_lane_ff  <= lane_in;
         s1_len_ff   <= req_data.edge_length;
         s1_alive_ff <= req_data.edge_alive;
         s1_last_ff  <= req_data.last_edge;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_list_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (!found_ff && (edge_position_ff == '0)
                                   && (first_index_ff == '0)))
      else $error("list state not cleared after last edge");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(edge_position_ff) && $stable(found_ff)))
      else $error("list state moved without a transfer");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.edge_matches) |-> rsp_data.any_match)
      else $error("matching edge without found flag");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.any_match) |-> (rsp_data.first_match_index == '0))
      else $error("first index nonzero with no match");

endmodule

// ===== hdl/hpm_lane.sv =====
module hpm_lane
   import hpm_pkg::*;
(
   input  logic [LANE_W-1:0]                    lane_id,
   input  node_id_type   [MAX_ARITY-1:0]        node_id,
   input  pat_value_type [MAX_ARITY-1:0]        pat_value,
   output lane_info_type                        info
);

   node_id_type   own_node;
   pat_value_type own_pat;

   always_comb begin
      own_node = node_id[lane_id];
      own_pat  = pat_value[lane_id];
      info.node_first = 1'b1;
      info.pat_first  = 1'b1;
      info.first_pos  = lane_id;
      info.pat_lt     = '0;
      for (int j = MAX_ARITY - 1; j >= 0; j--) begin
         if (LANE_W'(j) < lane_id) begin
            if (node_id[j] == own_node) begin
               info.node_first = 1'b0;
               info.first_pos  = LANE_W'(j);
            end
            if (pat_value[j] == own_pat) begin
               info.pat_first = 1'b0;
            end
         end
         info.pat_lt[j] = (pat_value[j] < own_pat);
      end
   end

endmodule

// ===== hdl/hpm_merge.sv =====
module hpm_merge
   import hpm_pkg::*;
(
   input  lane_info_type [MAX_ARITY-1:0] lane,
   input  logic [LEN_W-1:0]              edge_length,
   input  logic                          edge_alive,
   input  logic [LEN_W-1:0]              pattern_length,
   output logic                          edge_matches
);

   logic [MAX_ARITY-1:0] active;
   logic [MAX_ARITY-1:0] node_first_vec;
   logic [MAX_ARITY-1:0] pat_first_vec;
   logic [MAX_ARITY-1:0] below;
   logic [MAX_ARITY-1:0] rank_bad;
   logic [CNT_W-1:0]     nrank;
   logic [CNT_W-1:0]     prank;
   logic                 len_ok;
   logic                 distinct_ok;

   always_comb begin
      for (int i = 0; i < MAX_ARITY; i++) begin
         active[i]         = (LEN_W'(i) < edge_length);
         node_first_vec[i] = lane[i].node_first;
         pat_first_vec[i]  = lane[i].pat_first;
      end
      rank_bad = '0;
      below    = '0;
      nrank    = '0;
      prank    = '0;
      for (int i = 0; i < MAX_ARITY; i++) begin
         for (int j = 0; j < MAX_ARITY; j++) begin
            below[j] = (LANE_W'(j) < lane[i].first_pos);
         end
         nrank       = popcount(node_first_vec & below);
         prank       = popcount(pat_first_vec & lane[i].pat_lt & active);
         rank_bad[i] = active[i] && (nrank != prank);
      end
      len_ok = (edge_length != '0) && (edge_length <= LEN_W'(MAX_ARITY))
               && (edge_length == pattern_length);
      distinct_ok = (popcount(node_first_vec & active) == popcount(pat_first_vec & active));
      edge_matches = edge_alive && len_ok && distinct_ok && (rank_bad == '0);
   end

endmodule
